### rtl/ttp_pkg.sv
`timescale 1ns / 1ps

package ttp_pkg;

  // Table and page sizes are powers of two; table indexes wrap by masking.
  localparam int MAP_WORDS_DEF     = 131072;
  localparam int PATTERN_WORDS_DEF = 4096;
  localparam int PAGE_CELLS_DEF    = 64;

  localparam int ADDR_W   = 17;
  localparam int WORD_W   = 16;
  localparam int COORD_W  = 13;
  localparam int CFG_W    = 12;
  localparam int PAL_W    = 4;
  localparam int IDX_W    = 12;
  // Widest low part of a tile coordinate kept for the page position.
  localparam int PAGE_LO_W = 6;

  localparam logic [1:0] FUNC_MAP_WR = 2'd0;
  localparam logic [1:0] FUNC_PAT_WR = 2'd1;
  localparam logic [1:0] FUNC_PLACE  = 2'd2;

  localparam logic [1:0] CFG_LEVEL_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_LEVEL_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PALETTE_BANK = 2'd2;
  localparam logic [1:0] CFG_CHAR_BASE    = 2'd3;

  typedef struct packed {
    logic [1:0]           func;
    logic                 in_level;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_W-1:0]    data;
    logic [PAGE_LO_W-1:0] col_lo;
    logic [PAGE_LO_W-1:0] row_lo;
  } ttp_tile_t;

endpackage

### rtl/ttp_in_if.sv
`timescale 1ns / 1ps

interface ttp_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         func;
  logic [ttp_pkg::ADDR_W-1:0]         table_addr;
  logic [ttp_pkg::WORD_W-1:0]         table_data;
  logic signed [ttp_pkg::COORD_W-1:0] tile_col;
  logic signed [ttp_pkg::COORD_W-1:0] tile_row;

  modport source (output valid, func, table_addr, table_data, tile_col, tile_row,
                  input ready);
  modport sink (input valid, func, table_addr, table_data, tile_col, tile_row,
                output ready);
endinterface

### rtl/ttp_out_if.sv
`timescale 1ns / 1ps

interface ttp_out_if;
  logic                       valid;
  logic                       ready;
  logic [ttp_pkg::IDX_W-1:0]  page_index;
  logic [ttp_pkg::WORD_W-1:0] name_word;
  logic                       last_cell;

  modport source (output valid, page_index, name_word, last_cell, input ready);
  modport sink (input valid, page_index, name_word, last_cell, output ready);
endinterface

### rtl/ttp_cell_emit.sv
`timescale 1ns / 1ps

module ttp_cell_emit #(
  parameter int PATTERN_WORDS = ttp_pkg::PATTERN_WORDS_DEF,
  parameter int PAGE_CELLS    = ttp_pkg::PAGE_CELLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tile_valid,
  input  ttp_pkg::ttp_tile_t         tile,
  output logic                       tile_ready,
  input  logic [ttp_pkg::WORD_W-1:0] map_q,
  input  logic [ttp_pkg::PAL_W-1:0]  pal,
  input  logic [ttp_pkg::CFG_W-1:0]  cbase,
  ttp_out_if.source                  out_ch
);

  localparam int PAW = $clog2(PATTERN_WORDS);
  localparam int PCW = $clog2(PAGE_CELLS);

  logic [ttp_pkg::WORD_W-1:0] pat_mem [PATTERN_WORDS];
  logic [ttp_pkg::WORD_W-1:0] pat_q_r;

  logic                       c_v_r;
  ttp_pkg::ttp_tile_t         c_r;
  logic [1:0]                 k_r;

  logic                       d_v_r;
  logic [ttp_pkg::IDX_W-1:0]  d_idx_r;
  logic                       d_last_r;

  logic                       o_v_r;
  logic [ttp_pkg::IDX_W-1:0]  o_idx_r;
  logic [ttp_pkg::WORD_W-1:0] o_name_r;
  logic                       o_last_r;

  logic                       is_place, o_free, d_mv, d_free, rd, c_done, pat_we;
  logic [ttp_pkg::WORD_W-1:0] pid;
  logic [ttp_pkg::WORD_W+1:0] pat_sel;
  logic [PCW-1:0]             cell_c, cell_r;
  logic [2*PCW-1:0]           cell_full;
  logic [ttp_pkg::WORD_W-1:0] name_nxt;

  assign is_place = c_r.func == ttp_pkg::FUNC_PLACE;
  assign o_free   = !o_v_r || out_ch.ready;
  assign d_mv     = d_v_r && o_free;
  assign d_free   = !d_v_r || d_mv;
  assign rd       = c_v_r && is_place && d_free;
  assign c_done   = c_v_r && (!is_place || (d_free && k_r == 2'd3));
  assign pat_we   = c_v_r && c_r.func == ttp_pkg::FUNC_PAT_WR;
  assign tile_ready = !c_v_r || c_done;

  // Outside the level the tile id is zero.
  assign pid       = c_r.in_level ? map_q : '0;
  assign pat_sel   = {pid, k_r};
  assign cell_c    = {c_r.col_lo[PCW-2:0], k_r[0]};
  assign cell_r    = {c_r.row_lo[PCW-2:0], k_r[1]};
  assign cell_full = {cell_r, cell_c};

  assign name_nxt = ({pat_q_r[ttp_pkg::WORD_W-2:0], 1'b0} | {pal, 12'b0})
                    + {4'b0, cbase};

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[c_r.addr[PAW-1:0]] <= c_r.data;
    end
    if (rd) begin
      pat_q_r <= pat_mem[pat_sel[PAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      k_r   <= 2'd0;
      d_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (tile_ready) begin
        c_v_r <= tile_valid;
      end
      if (rd) begin
        k_r <= k_r + 2'd1;
      end
      if (rd) begin
        d_v_r <= 1'b1;
      end else if (d_mv) begin
        d_v_r <= 1'b0;
      end
      if (d_mv) begin
        o_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        o_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tile_ready && tile_valid) begin
      c_r <= tile;
    end
    if (rd) begin
      d_idx_r  <= ttp_pkg::IDX_W'(cell_full);
      d_last_r <= k_r == 2'd3;
    end
    if (d_mv) begin
      o_idx_r  <= d_idx_r;
      o_name_r <= name_nxt;
      o_last_r <= d_last_r;
    end
  end

  assign out_ch.valid      = o_v_r;
  assign out_ch.page_index = o_idx_r;
  assign out_ch.name_word  = o_name_r;
  assign out_ch.last_cell  = o_last_r;

endmodule

### rtl/tile_to_pattern_name_writer.sv
// Table write beats retire at one per cycle unless a place beat or output stall holds them.
// A place beat moves through stages A, B, C, the pattern read and output registers, one cell
// per cycle while out_ch is ready; C holds it until its four pattern reads on one port end.
// Synchronous active-low reset clears the pipeline and config registers; both
// tables come up undefined and need no clearing pass.
`timescale 1ns / 1ps

module tile_to_pattern_name_writer #(
  parameter int MAP_WORDS     = ttp_pkg::MAP_WORDS_DEF,
  parameter int PATTERN_WORDS = ttp_pkg::PATTERN_WORDS_DEF,
  parameter int PAGE_CELLS    = ttp_pkg::PAGE_CELLS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ttp_in_if.sink                    in_ch,
  ttp_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [ttp_pkg::CFG_W-1:0] cfg_data
);

  localparam int MAW = $clog2(MAP_WORDS);
  localparam int PCW = $clog2(PAGE_CELLS);

  logic [ttp_pkg::CFG_W-1:0] width_r, height_r, cbase_r;
  logic [ttp_pkg::PAL_W-1:0] pal_r;

  // Stage A: registered input beat
  logic                                a_v_r;
  logic [1:0]                          a_func_r;
  logic [ttp_pkg::ADDR_W-1:0]          a_addr_r;
  logic [ttp_pkg::WORD_W-1:0]          a_data_r;
  logic signed [ttp_pkg::COORD_W-1:0]  a_col_r, a_row_r;

  // Stage B: map memory access
  logic                                b_v_r;
  ttp_pkg::ttp_tile_t                  b_tile_r;
  logic [23:0]                         b_prod_r;
  logic [ttp_pkg::CFG_W-1:0]           b_col_r;

  logic [ttp_pkg::WORD_W-1:0]          map_mem [MAP_WORDS];
  logic [ttp_pkg::WORD_W-1:0]          map_q_r;

  logic                                a_mv, b_mv, c_ready, a_inside;
  logic [23:0]                         a_prod, b_idx;
  logic [MAW+ttp_pkg::ADDR_W-1:0]      b_addr_ext;
  logic [MAW-1:0]                      map_addr;
  logic                                map_we, map_re;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      pal_r    <= '0;
      cbase_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ttp_pkg::CFG_LEVEL_WIDTH:  width_r  <= cfg_data;
        ttp_pkg::CFG_LEVEL_HEIGHT: height_r <= cfg_data;
        ttp_pkg::CFG_PALETTE_BANK: pal_r    <= cfg_data[ttp_pkg::PAL_W-1:0];
        ttp_pkg::CFG_CHAR_BASE:    cbase_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign b_mv = b_v_r && c_ready;
  assign a_mv = a_v_r && (!b_v_r || b_mv);
  assign in_ch.ready = !a_v_r || a_mv;

  assign a_inside = !a_col_r[ttp_pkg::COORD_W-1] && !a_row_r[ttp_pkg::COORD_W-1]
                    && (a_col_r[11:0] < width_r) && (a_row_r[11:0] < height_r);
  assign a_prod   = a_row_r[11:0] * width_r;

  assign b_idx      = b_prod_r + {12'b0, b_col_r};
  assign b_addr_ext = {{MAW{1'b0}}, b_tile_r.addr};
  assign map_we     = b_mv && b_tile_r.func == ttp_pkg::FUNC_MAP_WR;
  assign map_re     = b_mv && b_tile_r.func == ttp_pkg::FUNC_PLACE;
  assign map_addr   = map_we ? b_addr_ext[MAW-1:0] : b_idx[MAW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        a_v_r <= in_ch.valid;
      end
      if (!b_v_r || b_mv) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      a_func_r <= in_ch.func;
      a_addr_r <= in_ch.table_addr;
      a_data_r <= in_ch.table_data;
      a_col_r  <= in_ch.tile_col;
      a_row_r  <= in_ch.tile_row;
    end
    if (a_mv) begin
      b_tile_r.func     <= a_func_r;
      b_tile_r.in_level <= a_inside;
      b_tile_r.addr     <= a_addr_r;
      b_tile_r.data     <= a_data_r;
      b_tile_r.col_lo   <= ttp_pkg::PAGE_LO_W'(a_col_r[PCW-2:0]);
      b_tile_r.row_lo   <= ttp_pkg::PAGE_LO_W'(a_row_r[PCW-2:0]);
      b_prod_r          <= a_prod;
      b_col_r           <= a_col_r[11:0];
    end
  end

  // Single port; accesses stay in beat order so reads see earlier writes.
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_addr] <= b_tile_r.data;
    end
    if (map_re) begin
      map_q_r <= map_mem[map_addr];
    end
  end

  ttp_cell_emit #(
    .PATTERN_WORDS (PATTERN_WORDS),
    .PAGE_CELLS    (PAGE_CELLS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .tile_valid (b_v_r),
    .tile       (b_tile_r),
    .tile_ready (c_ready),
    .map_q      (map_q_r),
    .pal        (pal_r),
    .cbase      (cbase_r),
    .out_ch     (out_ch)
  );

endmodule

### rtl/ttp_checker.sv
`timescale 1ns / 1ps

module ttp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ttp_pkg::IDX_W-1:0]  out_page_index,
  input logic [ttp_pkg::WORD_W-1:0] out_name_word,
  input logic                       out_last_cell
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_page_index)
      && $stable(out_name_word) && $stable(out_last_cell))
    else $error("stalled cell beat changed");

  // The final cell is bottom-right, always in an odd page column.
  a_last_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_cell |-> out_page_index[0])
    else $error("last cell not in odd column");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("cell beat valid after reset");

endmodule

bind tile_to_pattern_name_writer ttp_checker u_ttp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_page_index (out_ch.page_index),
  .out_name_word  (out_ch.name_word),
  .out_last_cell  (out_ch.last_cell)
);
